// ===== hw/rtl/rsc_pkg.sv =====
// Shared constants, payload types and the emitter start table of the shadow centroid block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

    localparam int RING_BITS     = 108;
    localparam int WINDOW_BITS   = 48;
    localparam int EMITTER_COUNT = 12;

    // Bits carried by the four input words; ring bits above this read as zero.
    localparam int PHYS_BITS = 108;

    localparam int EMITTER_W = 4;
    localparam int CENTER_W  = 8;
    localparam logic [CENTER_W-1:0] NO_SHADOW = 8'hFF;

    localparam int START_W = $clog2(RING_BITS);
    localparam int SUM_W   = $clog2(WINDOW_BITS * (WINDOW_BITS - 1) / 2 + 1);
    localparam int NUM_W   = SUM_W + 1;
    localparam int CNT_W   = $clog2(WINDOW_BITS + 1);

    localparam int GROUP_BITS = 8;
    localparam int GROUPS     = (WINDOW_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int GCNT_W     = $clog2(GROUP_BITS + 1);

    localparam int ADD_W = $clog2(2 * RING_BITS + 2 * WINDOW_BITS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int START_TABLE [16] = '{
        28, 45, 63, 82, 99, 10, 17, 35, 55, 73, 90, 0,
        0, 0, 0, 0
    };

    typedef struct packed {
        logic [31:0]          photo_word0;
        logic [31:0]          photo_word1;
        logic [31:0]          photo_word2;
        logic [11:0]          photo_word3;
        logic [EMITTER_W-1:0] emitter;
    } in_t;

    typedef struct packed {
        logic [CENTER_W-1:0]  center;
        logic [EMITTER_W-1:0] emitter_out;
    } out_t;

    // One classified scan handed from the front end to the divider.
    typedef struct packed {
        logic                 none;
        logic [NUM_W-1:0]     num;
        logic [CNT_W-1:0]     cnt;
        logic [START_W-1:0]   start;
        logic [EMITTER_W-1:0] emitter;
    } job_t;

endpackage : rsc_pkg

`default_nettype wire

// ===== hw/rtl/rsc_front.sv =====
// Front end: window extraction per emitter, then grouped bit count and index sum, then classification.
// Depends on rsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsc_front
    import rsc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      job_valid,
    input  wire logic job_ready,
    output job_t      job_data
);

    typedef struct packed {
        logic [WINDOW_BITS-1:0] win;
        logic [START_W-1:0]     start;
        logic [EMITTER_W-1:0]   emitter;
        logic                   bad;
    } win_t;

    typedef struct packed {
        logic [GROUPS-1:0][GCNT_W-1:0] gcnt;
        logic [GROUPS-1:0][SUM_W-1:0]  gsum;
        logic                          first;
        logic                          last;
        logic [START_W-1:0]            start;
        logic [EMITTER_W-1:0]          emitter;
        logic                          bad;
    } part_t;

    logic [PHYS_BITS-1:0]   phys;
    logic [RING_BITS-1:0]   ring;
    logic [WINDOW_BITS-1:0] win_all [EMITTER_COUNT];

    win_t  a_next, a_reg;
    part_t b_next, b_reg;
    logic  av_reg, bv_reg;
    logic  adv_a, adv_b;

    assign phys = {s_data.photo_word3, s_data.photo_word2,
                   s_data.photo_word1, s_data.photo_word0};

    for (genvar k = 0; k < RING_BITS; k++) begin : g_ring
        if (k < PHYS_BITS) begin : g_live
            assign ring[k] = phys[k];
        end else begin : g_dark
            assign ring[k] = 1'b0;
        end
    end

    // Each emitter's window is fixed wiring from the ring.
    for (genvar e = 0; e < EMITTER_COUNT; e++) begin : g_emit
        localparam int S = START_TABLE[e] % RING_BITS;
        for (genvar i = 0; i < WINDOW_BITS; i++) begin : g_bit
            assign win_all[e][i] = ring[(S + i) % RING_BITS];
        end
    end

    always_comb begin
        a_next         = '0;
        a_next.emitter = s_data.emitter;
        a_next.bad     = 1'b1;
        for (int e = 0; e < EMITTER_COUNT; e++) begin
            if (s_data.emitter == EMITTER_W'(e)) begin
                a_next.win   = win_all[e];
                a_next.start = START_W'(START_TABLE[e] % RING_BITS);
                a_next.bad   = 1'b0;
            end
        end
    end

    always_comb begin
        b_next         = '0;
        b_next.first   = a_reg.win[0];
        b_next.last    = a_reg.win[WINDOW_BITS-1];
        b_next.start   = a_reg.start;
        b_next.emitter = a_reg.emitter;
        b_next.bad     = a_reg.bad;
        for (int g = 0; g < GROUPS; g++) begin
            for (int j = 0; j < GROUP_BITS; j++) begin
                if (g * GROUP_BITS + j < WINDOW_BITS) begin
                    if (a_reg.win[g * GROUP_BITS + j]) begin
                        b_next.gcnt[g] = b_next.gcnt[g] + GCNT_W'(1);
                        b_next.gsum[g] = b_next.gsum[g] + SUM_W'(g * GROUP_BITS + j);
                    end
                end
            end
        end
    end

    // Total the groups and classify.
    always_comb begin
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
        cnt = '0;
        sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            cnt = cnt + CNT_W'(b_reg.gcnt[g]);
            sum = sum + b_reg.gsum[g];
        end
        job_data.none    = b_reg.bad | b_reg.first | b_reg.last | (cnt == '0);
        job_data.num     = {sum, 1'b0};
        job_data.cnt     = cnt;
        job_data.start   = b_reg.start;
        job_data.emitter = b_reg.emitter;
    end

    assign adv_b     = !bv_reg || job_ready;
    assign adv_a     = !av_reg || adv_b;
    assign s_ready   = adv_a;
    assign job_valid = bv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            av_reg <= 1'b0;
            bv_reg <= 1'b0;
        end else begin
            if (adv_a) begin
                av_reg <= s_valid;
            end
            if (adv_b) begin
                bv_reg <= av_reg;
            end
        end
        if (adv_a) begin
            a_reg <= a_next;
        end
        if (adv_b) begin
            b_reg <= b_next;
        end
    end

endmodule : rsc_front

`default_nettype wire

// ===== hw/rtl/rsc_queue.sv =====
// Short first-in first-out queue of classified scans between front end and divider.
// Depends on rsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsc_queue
    import rsc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire job_t wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_data
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign wr_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule : rsc_queue

`default_nettype wire

// ===== hw/rtl/rsc_back.sv =====
// Back end: restoring divider pipelined one quotient bit per stage, then offset, wrap and output register.
// Depends on rsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsc_back
    import rsc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic job_valid,
    output logic      job_ready,
    input  wire job_t job_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    typedef struct packed {
        logic                 none;
        logic [CNT_W-1:0]     rem;
        logic [NUM_W-1:0]     num;
        logic [NUM_W-1:0]     quo;
        logic [CNT_W-1:0]     den;
        logic [START_W-1:0]   start;
        logic [EMITTER_W-1:0] emitter;
    } div_t;

    function automatic div_t div_step(input div_t d);
        div_t           r;
        logic [CNT_W:0] trial;
        logic           ge;
        r     = d;
        trial = {d.rem, d.num[NUM_W-1]};
        ge    = (trial >= {1'b0, d.den});
        if (ge) begin
            trial = trial - {1'b0, d.den};
        end
        r.rem = trial[CNT_W-1:0];
        r.num = d.num << 1;
        r.quo = {d.quo[NUM_W-2:0], ge};
        return r;
    endfunction

    div_t            seed;
    div_t            div_reg [NUM_W];
    logic [NUM_W-1:0] dv_reg;
    logic [NUM_W-1:0] adv;
    logic            adv_out;
    logic            ov_reg;
    out_t            out_reg, out_next;

    always_comb begin
        seed         = '0;
        seed.none    = job_data.none;
        seed.num     = job_data.num;
        seed.den     = job_data.cnt;
        seed.start   = job_data.start;
        seed.emitter = job_data.emitter;
    end

    assign adv_out = !ov_reg || m_ready;

    always_comb begin
        logic nxt;
        nxt = adv_out;
        for (int k = NUM_W - 1; k >= 0; k--) begin
            adv[k] = !dv_reg[k] || nxt;
            nxt    = adv[k];
        end
    end

    assign job_ready = adv[0];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        div_t stage_in;
        logic valid_in;
        if (k == 0) begin : g_head
            assign stage_in = seed;
            assign valid_in = job_valid;
        end else begin : g_body
            assign stage_in = div_reg[k-1];
            assign valid_in = dv_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                dv_reg[k] <= valid_in;
            end
            if (adv[k]) begin
                div_reg[k] <= div_step(stage_in);
            end
        end
    end

    // Add the doubled start, wrap once round the ring, substitute the no-shadow code.
    always_comb begin
        logic [ADD_W-1:0] total;
        total = ADD_W'(div_reg[NUM_W-1].quo) + ADD_W'({div_reg[NUM_W-1].start, 1'b0});
        if (total >= ADD_W'(2 * RING_BITS)) begin
            total = total - ADD_W'(2 * RING_BITS);
        end
        out_next.center      = div_reg[NUM_W-1].none ? NO_SHADOW : CENTER_W'(total);
        out_next.emitter_out = div_reg[NUM_W-1].emitter;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (adv_out) begin
            ov_reg <= dv_reg[NUM_W-1];
        end
        if (adv_out) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = ov_reg;
    assign m_data  = out_reg;

endmodule : rsc_back

`default_nettype wire

// ===== hw/rtl/ring_shadow_centroid.sv =====
// Shadow centroid finder for a ring of photodiodes: top level joining front end, queue and divider.
// Depends on rsc_pkg, rsc_front, rsc_queue and rsc_back.
`timescale 1ns / 1ps
`default_nettype none

// Takes one photodiode scan per transaction (108 ring bits in four words plus an emitter
// number) and returns one transaction with the shadow centre in half-diode units, or 255
// where the window has a lit edge, no lit bit, or the emitter has no table entry. The
// emitter number is echoed with every result. One scan is taken every clock cycle while
// the result side keeps up; results leave in arrival order. A scan passes through two
// front-end stages (window select, grouped count and index sum), the four-entry queue,
// one divider stage per quotient bit, and the output register. Stalls on the result side
// back up through the divider into the queue; the front end keeps filling the queue
// until it is full, so short output stalls do not reach the input.
module ring_shadow_centroid
    import rsc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic fq_valid, fq_ready;
    job_t fq_data;
    logic qb_valid, qb_ready;
    job_t qb_data;

    // Classify each scan and hand it on as a divide job.
    rsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job_data  (fq_data)
    );

    // Hold jobs so the two halves stall independently.
    rsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // Divide, offset by the start position and drive the result channel.
    rsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job_data  (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule : ring_shadow_centroid

`default_nettype wire
